// ===== design/calt_pkg.sv =====
`default_nettype none
package calt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [1:0] ACT_CHECK  = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;

  localparam logic [2:0] REG_FILTER_ADDR = 3'd0;

  typedef struct packed {
    logic        fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  prefix;
  } entry_t;

  typedef struct packed {
    logic match;
    logic equal;
  } cmp_t;

endpackage
`default_nettype wire

// ===== design/calt_store.sv =====
`default_nettype none
module calt_store (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [calt_pkg::IDX_W-1:0] waddr,
  input  wire calt_pkg::entry_t           wdata,
  input  wire logic [calt_pkg::IDX_W-1:0] raddr,
  output calt_pkg::entry_t                rdata
);

  calt_pkg::entry_t mem [calt_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/calt_cmp.sv =====
`default_nettype none
module calt_cmp (
  input  wire calt_pkg::entry_t ent,
  input  wire calt_pkg::entry_t key,
  output calt_pkg::cmp_t        res
);

  logic [31:0] m32;
  logic [63:0] mh;
  logic [63:0] ml;
  logic [7:0]  lo_sh;
  logic        fam_eq;
  logic        v4_hit;
  logic        v6_hit;

  // masks follow the stored entry's prefix
  always_comb begin
    lo_sh  = ent.prefix - 8'd64;
    m32    = (ent.prefix >= 8'd32) ? '1 : ~(32'hFFFF_FFFF >> ent.prefix[4:0]);
    mh     = (ent.prefix >= 8'd64) ? '1 : ~({64{1'b1}} >> ent.prefix[5:0]);
    if (ent.prefix >= 8'd128) begin
      ml = '1;
    end else if (ent.prefix > 8'd64) begin
      ml = ~({64{1'b1}} >> lo_sh[5:0]);
    end else begin
      ml = '0;
    end
    fam_eq = (ent.fam == key.fam);
    v4_hit = (((key.lo[31:0] ^ ent.lo[31:0]) & m32) == 32'd0);
    v6_hit = (((key.hi ^ ent.hi) & mh) == 64'd0) && (((key.lo ^ ent.lo) & ml) == 64'd0);
    res.match = fam_eq && (ent.fam ? v6_hit : v4_hit);
    res.equal = (ent == key);
  end

endmodule
`default_nettype wire

// ===== design/cidr_allowlist_match_table_core.sv =====
// cidr allowlist match table
// input channel (in_valid/in_stall) takes one beat per action: check, add,
// remove or clear, with family, 128-bit address and prefix length.
// output channel (out_valid/out_stall) returns one beat per action: verdict,
// status, entry count and the check/allowed/denied counters after it.
// entries live in a 64-deep synchronous memory; a scan reads one entry per
// cycle and compares it on the next. a check, add or remove scans the
// entries in use until it hits (a check or a duplicate add that hits early
// stops sooner); a remove that finds its entry then moves the later entries
// down. clear, unfiltered checks, checks on an empty table and adds to a
// full table skip the scan and go straight to the result.
// one action is in flight at a time; the next beat is taken once the result
// sits in the output register, even while that result is still stalled.
// a stalled result holds the output; the block finishes no further action
// until it is taken.
// rst (synchronous) empties the table, zeroes the counters and disables
// filtering; memory contents are not cleared, only entries below the count
// are ever read. filter_enabled sits at byte address 0 of the apb port.
`default_nettype none
module cidr_allowlist_match_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic        is_ipv6,
  input  wire logic [63:0] addr_hi,
  input  wire logic [63:0] addr_lo,
  input  wire logic [7:0]  pfx_len,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             verdict,
  output logic      [1:0]  op_status,
  output logic      [6:0]  entries_used,
  output logic      [31:0] checks_total,
  output logic      [31:0] allowed_total,
  output logic      [31:0] denied_total
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int IW = calt_pkg::IDX_W;
  localparam int CW = calt_pkg::CNT_W;

  logic [1:0]       state, state_next;
  logic [CW-1:0]    rd_idx, rd_idx_next;
  logic             pend, pend_next;
  logic [IW-1:0]    pidx;
  logic [1:0]       act, act_next;
  calt_pkg::entry_t key, key_next, nkey;
  logic             res_verdict, res_verdict_next;
  logic [1:0]       res_status, res_status_next;
  logic [CW-1:0]    count, count_upd, count_upd_next;
  logic [31:0]      checks, allowed, denied;
  logic             filt;

  logic             we;
  logic [IW-1:0]    waddr;
  calt_pkg::entry_t wdata;
  calt_pkg::entry_t rdata;
  calt_pkg::cmp_t   cmp;

  logic issue, out_free, hit;

  calt_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rdata)
  );

  calt_cmp u_cmp (
    .ent (rdata),
    .key (key),
    .res (cmp)
  );

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == calt_pkg::REG_FILTER_ADDR) ? {31'd0, filt} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == calt_pkg::REG_FILTER_ADDR) begin
      filt <= pwdata[0];
    end
  end

  // normalised key
  always_comb begin
    nkey.fam = is_ipv6;
    if (is_ipv6) begin
      nkey.hi     = addr_hi;
      nkey.lo     = addr_lo;
      nkey.prefix = (pfx_len > 8'd128) ? 8'd128 : pfx_len;
    end else begin
      nkey.hi     = 64'd0;
      nkey.lo     = {32'd0, addr_lo[31:0]};
      nkey.prefix = (pfx_len > 8'd32) ? 8'd32 : pfx_len;
    end
  end

  assign issue    = (rd_idx < count);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign hit      = pend && ((act == calt_pkg::ACT_CHECK) ? cmp.match : cmp.equal);

  always_comb begin
    state_next       = state;
    rd_idx_next      = rd_idx + CW'(issue);
    pend_next        = issue && (state == ST_SCAN || state == ST_SHIFT);
    act_next         = act;
    key_next         = key;
    res_verdict_next = res_verdict;
    res_status_next  = res_status;
    count_upd_next   = count_upd;
    we               = 1'b0;
    waddr            = count[IW-1:0];
    wdata            = key;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          key_next         = nkey;
          act_next         = action;
          res_verdict_next = 1'b0;
          res_status_next  = calt_pkg::STAT_OK;
          count_upd_next   = count;
          rd_idx_next      = '0;
          pend_next        = 1'b0;
          case (action)
            calt_pkg::ACT_CLEAR: begin
              count_upd_next = '0;
              state_next     = ST_DONE;
            end
            calt_pkg::ACT_CHECK: begin
              state_next = (!filt || count == '0) ? ST_DONE : ST_SCAN;
            end
            calt_pkg::ACT_ADD: begin
              if (count >= CW'(calt_pkg::MAX_ENTRIES)) begin
                res_status_next = calt_pkg::STAT_FULL;
                state_next      = ST_DONE;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: state_next = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          pend_next = 1'b0;
          if (act == calt_pkg::ACT_REMOVE) begin
            rd_idx_next = {1'b0, pidx} + CW'(1);
            state_next  = ST_SHIFT;
          end else begin
            state_next = ST_DONE;
          end
        end else if (!issue && !pend) begin
          case (act)
            calt_pkg::ACT_CHECK: res_verdict_next = 1'b1;
            calt_pkg::ACT_ADD: begin
              we             = 1'b1;
              count_upd_next = count + CW'(1);
            end
            default: res_status_next = calt_pkg::STAT_NOTFOUND;
          endcase
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (pend) begin
          we    = 1'b1;
          waddr = pidx - IW'(1);
          wdata = rdata;
        end
        if (!issue && !pend) begin
          count_upd_next = count - CW'(1);
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      count     <= '0;
      checks    <= '0;
      allowed   <= '0;
      denied    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
        count     <= count_upd;
        if (act == calt_pkg::ACT_CHECK) begin
          checks <= checks + 32'd1;
          if (res_verdict) begin
            denied <= denied + 32'd1;
          end else begin
            allowed <= allowed + 32'd1;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx      <= rd_idx_next;
    pidx        <= rd_idx[IW-1:0];
    act         <= act_next;
    key         <= key_next;
    res_verdict <= res_verdict_next;
    res_status  <= res_status_next;
    count_upd   <= count_upd_next;
    if (state == ST_DONE && out_free) begin
      verdict   <= res_verdict;
      op_status <= res_status;
    end
  end

  assign entries_used  = 7'(count);
  assign checks_total  = checks;
  assign allowed_total = allowed;
  assign denied_total  = denied;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != ST_IDLE))
    else $error("accepted beat did not start an action");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(calt_pkg::MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    pend |-> ({1'b0, pidx} < count))
    else $error("compared an entry beyond the count");

  a_out_only_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside completion");

endmodule
`default_nettype wire

// ===== tb/tb_cidr_allowlist_match_table_core.sv =====
`timescale 1ns / 1ps
module tb_cidr_allowlist_match_table_core;

  typedef struct {
    logic [1:0]  act;
    logic        fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  plen;
  } action_t;

  typedef struct {
    logic        verdict;
    logic [1:0]  status;
    logic [6:0]  used;
    logic [31:0] checks;
    logic [31:0] allowed;
    logic [31:0] denied;
  } outcome_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic [1:0] action = '0;
  logic is_ipv6 = 0;
  logic [63:0] addr_hi = '0, addr_lo = '0;
  logic [7:0] pfx_len = '0;
  logic out_valid, out_stall = 0;
  logic verdict;
  logic [1:0] op_status;
  logic [6:0] entries_used;
  logic [31:0] checks_total, allowed_total, denied_total;

  cidr_allowlist_match_table_core dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  logic [63:0] tbl_hi [calt_pkg::MAX_ENTRIES];
  logic [63:0] tbl_lo [calt_pkg::MAX_ENTRIES];
  logic        tbl_fam [calt_pkg::MAX_ENTRIES];
  logic [7:0]  tbl_plen [calt_pkg::MAX_ENTRIES];
  int unsigned tbl_count;
  logic [31:0] n_checks, n_allowed, n_denied;
  logic        filter_on;

  action_t  pending_actions[$];
  outcome_t expected_outcomes[$];
  int errors = 0, n_sent = 0, n_seen = 0;
  int send_idle = 0, recv_idle = 0;
  int checks_seen = 0, denied_seen = 0, full_seen = 0, notfound_seen = 0;

  function automatic logic [127:0] prefix_mask(logic fam, logic [7:0] p);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 128; b++)
      if (b < p) m[127 - b] = 1'b1;
    if (!fam) m = {96'd0, m[127:96]};
    return m;
  endfunction

  function automatic outcome_t predict_acl(action_t a);
    outcome_t r;
    logic [63:0] hi, lo;
    logic [7:0] p;
    logic [127:0] m;
    logic hit;
    int idx;
    hi = a.hi; lo = a.lo; p = a.plen;
    if (!a.fam) begin
      hi = '0;
      lo = {32'd0, lo[31:0]};
      if (p > 8'd32) p = 8'd32;
    end else if (p > 8'd128) p = 8'd128;
    r.verdict = 1'b0;
    r.status = calt_pkg::STAT_OK;
    case (a.act)
      calt_pkg::ACT_CHECK: begin
        hit = 1'b0;
        n_checks++;
        if (!filter_on || tbl_count == 0) hit = 1'b1;
        else for (int i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_fam[i] == a.fam) begin
            m = prefix_mask(a.fam, tbl_plen[i]);
            if ((({hi, lo} ^ {tbl_hi[i], tbl_lo[i]}) & m) == '0) hit = 1'b1;
          end
        end
        if (hit) n_allowed++;
        else begin
          n_denied++;
          r.verdict = 1'b1;
        end
      end
      calt_pkg::ACT_ADD: begin
        if (tbl_count >= calt_pkg::MAX_ENTRIES) r.status = calt_pkg::STAT_FULL;
        else begin
          hit = 1'b0;
          for (int i = 0; i < tbl_count; i++)
            if (tbl_fam[i] == a.fam && tbl_hi[i] == hi && tbl_lo[i] == lo && tbl_plen[i] == p)
              hit = 1'b1;
          if (!hit) begin
            tbl_hi[tbl_count] = hi; tbl_lo[tbl_count] = lo;
            tbl_fam[tbl_count] = a.fam; tbl_plen[tbl_count] = p;
            tbl_count++;
          end
        end
      end
      calt_pkg::ACT_REMOVE: begin
        r.status = calt_pkg::STAT_NOTFOUND;
        idx = -1;
        for (int i = 0; i < tbl_count && idx < 0; i++)
          if (tbl_fam[i] == a.fam && tbl_hi[i] == hi && tbl_lo[i] == lo && tbl_plen[i] == p)
            idx = i;
        if (idx >= 0) begin
          for (int j = idx; j + 1 < tbl_count; j++) begin
            tbl_hi[j] = tbl_hi[j+1]; tbl_lo[j] = tbl_lo[j+1];
            tbl_fam[j] = tbl_fam[j+1]; tbl_plen[j] = tbl_plen[j+1];
          end
          tbl_count--;
          r.status = calt_pkg::STAT_OK;
        end
      end
      default: tbl_count = 0;
    endcase
    r.used = tbl_count[6:0];
    r.checks = n_checks;
    r.allowed = n_allowed;
    r.denied = n_denied;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(predict_acl(pending_actions.pop_front()));
        n_sent++;
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (pending_actions.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          action <= pending_actions[0].act;
          is_ipv6 <= pending_actions[0].fam;
          addr_hi <= pending_actions[0].hi;
          addr_lo <= pending_actions[0].lo;
          pfx_len <= pending_actions[0].plen;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_seen++;
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat", $time);
        end else begin
          e = expected_outcomes.pop_front();
          if (verdict !== e.verdict || op_status !== e.status || entries_used !== e.used ||
              checks_total !== e.checks || allowed_total !== e.allowed ||
              denied_total !== e.denied) begin
            errors++;
            $display("%0t mismatch: expected v%0d s%0d n%0d c%0d a%0d d%0d got v%0d s%0d n%0d c%0d a%0d d%0d",
                     $time, e.verdict, e.status, e.used, e.checks, e.allowed, e.denied,
                     verdict, op_status, entries_used, checks_total, allowed_total,
                     denied_total);
          end
          if (e.verdict) denied_seen++;
          if (e.status == calt_pkg::STAT_FULL) full_seen++;
          if (e.status == calt_pkg::STAT_NOTFOUND) notfound_seen++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic write_filter(logic en);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= calt_pkg::REG_FILTER_ADDR;
    pwdata <= {31'd0, en};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    filter_on = en;
  endtask

  task automatic drain();
    while (pending_actions.size() > 0 || expected_outcomes.size() > 0 || in_valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic queue_action(logic [1:0] act, logic fam, logic [63:0] hi, logic [63:0] lo,
                              logic [7:0] plen);
    action_t a;
    a.act = act; a.fam = fam; a.hi = hi; a.lo = lo; a.plen = plen;
    pending_actions.push_back(a);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  function automatic logic rand1();
    return 1'($urandom_range(1));
  endfunction

  // random items near a small pool of prefixes so checks and removes hit
  task automatic random_batch(int count);
    logic [63:0] pool_hi [8];
    logic [63:0] pool_lo [8];
    logic        pool_fam [8];
    logic [7:0]  pool_plen [8];
    int k, r;
    logic [63:0] hi, lo;
    for (int i = 0; i < 8; i++) begin
      pool_hi[i] = rand64(); pool_lo[i] = rand64(); pool_fam[i] = rand1();
      pool_plen[i] = rand8();
    end
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(7);
      r = $urandom_range(99);
      hi = pool_hi[k]; lo = pool_lo[k];
      if ($urandom_range(3) == 0) begin
        hi ^= rand64() >> $urandom_range(63);
        lo ^= rand64() >> $urandom_range(63);
      end
      if (r < 45) queue_action(calt_pkg::ACT_CHECK, pool_fam[k] ^ ($urandom_range(9) == 0),
                               hi, lo, rand8());
      else if (r < 70) queue_action(calt_pkg::ACT_ADD, pool_fam[k], pool_hi[k], pool_lo[k],
                                    pool_plen[k]);
      else if (r < 78) queue_action(calt_pkg::ACT_ADD, rand1(), rand64(), rand64(), rand8());
      else if (r < 92) queue_action(calt_pkg::ACT_REMOVE, pool_fam[k], pool_hi[k], pool_lo[k],
                                    ($urandom_range(4) == 0) ? rand8() : pool_plen[k]);
      else if (r < 97) queue_action(calt_pkg::ACT_CHECK, rand1(), rand64(), rand64(), rand8());
      else queue_action(calt_pkg::ACT_CLEAR, rand1(), rand64(), rand64(), rand8());
    end
  endtask

  initial begin
    tbl_count = 0; n_checks = '0; n_allowed = '0; n_denied = '0; filter_on = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: unfiltered, empty table, then extremes
    queue_action(calt_pkg::ACT_CHECK, 1'b1, '1, '1, 8'hFF);
    queue_action(calt_pkg::ACT_ADD, 1'b0, '1, 64'hFFFF_FFFF_C0A8_0100, 8'd24);
    queue_action(calt_pkg::ACT_CHECK, 1'b0, '0, 64'h0A00_0001, 8'd0);
    drain();
    write_filter(1'b1);
    queue_action(calt_pkg::ACT_CHECK, 1'b0, '0, 64'hC0A8_01FE, 8'd0);
    queue_action(calt_pkg::ACT_CHECK, 1'b0, '0, 64'hC0A8_02FE, 8'd0);
    queue_action(calt_pkg::ACT_ADD, 1'b0, '0, 64'hC0A8_0100, 8'd200);
    queue_action(calt_pkg::ACT_ADD, 1'b0, '1, 64'h1234_5678_C0A8_0100, 8'd24);
    queue_action(calt_pkg::ACT_ADD, 1'b1, 64'h2001_0DB8_0000_0000, '0, 8'd32);
    queue_action(calt_pkg::ACT_CHECK, 1'b1, 64'h2001_0DB8_FFFF_0000, '1, 8'd7);
    queue_action(calt_pkg::ACT_CHECK, 1'b1, 64'h2001_0DB9_0000_0000, '0, 8'd7);
    queue_action(calt_pkg::ACT_ADD, 1'b1, '1, '1, 8'hFF);
    queue_action(calt_pkg::ACT_CHECK, 1'b1, '1, '1, 8'd0);
    queue_action(calt_pkg::ACT_CHECK, 1'b1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0);
    queue_action(calt_pkg::ACT_REMOVE, 1'b1, '1, '1, 8'd127);
    queue_action(calt_pkg::ACT_REMOVE, 1'b1, '1, '1, 8'd128);
    queue_action(calt_pkg::ACT_REMOVE, 1'b0, '0, 64'hC0A8_0100, 8'd33);
    queue_action(calt_pkg::ACT_ADD, 1'b1, '0, '0, 8'd0);
    queue_action(calt_pkg::ACT_CHECK, 1'b1, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555,
                 8'd0);
    queue_action(calt_pkg::ACT_CHECK, 1'b0, '0, 64'hFFFF_FFFF, 8'd0);
    queue_action(calt_pkg::ACT_CLEAR, 1'b0, '0, '0, 8'd0);
    queue_action(calt_pkg::ACT_CHECK, 1'b0, '0, 64'hFFFF_FFFF, 8'd0);
    for (int i = 0; i < 66; i++)
      queue_action(calt_pkg::ACT_ADD, i[0], rand64(), rand64(), rand8());
    queue_action(calt_pkg::ACT_CHECK, 1'b1, rand64(), rand64(), 8'd0);
    queue_action(calt_pkg::ACT_REMOVE, 1'b0, '0, 64'hDEAD, 8'd5);
    queue_action(calt_pkg::ACT_CLEAR, 1'b1, '1, '1, 8'hFF);
    drain();

    send_idle = 9; recv_idle = 63;
    random_batch(400);
    drain();
    write_filter(1'b0);
    send_idle = 63; recv_idle = 9;
    random_batch(400);
    drain();
    write_filter(1'b1);
    send_idle = 0; recv_idle = 0;
    random_batch(400);
    drain();

    $display("%0d actions sent, %0d results checked: %0d checks, %0d denied, %0d full, %0d not found",
             n_sent, n_seen, n_checks, denied_seen, full_seen, notfound_seen);
    $display("filter toggled off and on, idling on each side and none, table filled past capacity");
    if (errors == 0) $display("PASS cidr_allowlist_match_table_core");
    else $display("FAIL cidr_allowlist_match_table_core");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL cidr_allowlist_match_table_core");
    $finish;
  end

endmodule

// ===== sim.f =====
design/calt_pkg.sv
design/calt_store.sv
design/calt_cmp.sv
design/cidr_allowlist_match_table_core.sv
tb/tb_cidr_allowlist_match_table_core.sv
